// ===== rtl/largest_free_square_finder_core_defines.svh =====
// assertion helpers for the rtl
`ifndef LARGEST_FREE_SQUARE_FINDER_CORE_DEFINES_SVH
`define LARGEST_FREE_SQUARE_FINDER_CORE_DEFINES_SVH

// checked only outside reset
`define LFSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LFSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lfsf_pkg.sv =====
`default_nettype none

package lfsf_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int POS_W  = 10;
  localparam int SIZE_W = 11;
  localparam int CNT_W  = 11;
  localparam int CNT_MAX = 2047;

  localparam logic [CNT_W-1:0]  CNT_RESET = 11'd1024;
  localparam logic [SIZE_W-1:0] SIZE_SAT  = 11'h7ff;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COL_COUNT = 1'b0,
    REG_ROW_COUNT = 1'b1
  } cfg_reg_t;

  // raster position of the cell being taken
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             grid_end;
  } pos_t;

  typedef struct packed {
    logic              found;
    logic [SIZE_W-1:0] square_size;
    logic [POS_W-1:0]  top_row;
    logic [POS_W-1:0]  left_col;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/lfsf_if.sv =====
`default_nettype none

interface lfsf_cell_if;
  logic valid;
  logic ready;
  logic cell_free;
  modport source (output valid, output cell_free, input ready);
  modport sink (input valid, input cell_free, output ready);
endinterface

interface lfsf_result_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [lfsf_pkg::SIZE_W-1:0] square_size;
  logic [lfsf_pkg::POS_W-1:0]  top_row;
  logic [lfsf_pkg::POS_W-1:0]  left_col;
  modport source (output valid, output found, output square_size, output top_row,
                  output left_col, input ready);
  modport sink (input valid, input found, input square_size, input top_row,
                input left_col, output ready);
endinterface

interface lfsf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfsf_pkg::CFG_IDX_W-1:0] index;
  logic [lfsf_pkg::CNT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lfsf_ram.sv =====
`default_nettype none

module lfsf_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfsf_pos.sv =====
`default_nettype none

module lfsf_pos #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic [lfsf_pkg::CNT_W-1:0]    col_count,
  input  wire logic [lfsf_pkg::CNT_W-1:0]    row_count,
  output      lfsf_pkg::pos_t                cur,
  output      logic [$clog2(MAX_COLS)-1:0]   idx
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int COL_LIM_I = (MAX_COLS > lfsf_pkg::CNT_MAX) ? lfsf_pkg::CNT_MAX : MAX_COLS;
  localparam int ROW_LIM_I = (MAX_ROWS > lfsf_pkg::CNT_MAX) ? lfsf_pkg::CNT_MAX : MAX_ROWS;
  localparam logic [lfsf_pkg::CNT_W-1:0] COL_LIM = COL_LIM_I[lfsf_pkg::CNT_W-1:0];
  localparam logic [lfsf_pkg::CNT_W-1:0] ROW_LIM = ROW_LIM_I[lfsf_pkg::CNT_W-1:0];
  localparam logic [AW-1:0] IDX_TOP = AW'(MAX_COLS - 1);

  logic [lfsf_pkg::POS_W-1:0] col_pos;
  logic [lfsf_pkg::POS_W-1:0] row_pos;
  logic [lfsf_pkg::CNT_W-1:0] cols;
  logic [lfsf_pkg::CNT_W-1:0] rows;
  logic [lfsf_pkg::CNT_W-1:0] col_inc;
  logic [lfsf_pkg::CNT_W-1:0] row_inc;
  logic                       col_end;
  logic                       row_end;

  // zero counts as one, anything past the storage as the limit
  always_comb begin
    if (col_count == '0) begin
      cols = lfsf_pkg::CNT_W'(1);
    end else if (col_count > COL_LIM) begin
      cols = COL_LIM;
    end else begin
      cols = col_count;
    end
    if (row_count == '0) begin
      rows = lfsf_pkg::CNT_W'(1);
    end else if (row_count > ROW_LIM) begin
      rows = ROW_LIM;
    end else begin
      rows = row_count;
    end
  end

  assign col_inc = {1'b0, col_pos} + lfsf_pkg::CNT_W'(1);
  assign row_inc = {1'b0, row_pos} + lfsf_pkg::CNT_W'(1);
  assign col_end = col_inc >= cols;
  assign row_end = row_inc >= rows;

  assign cur.col      = col_pos;
  assign cur.row      = row_pos;
  assign cur.grid_end = col_end && row_end;

  assign idx = (32'(col_pos) < MAX_COLS) ? AW'(col_pos) : IDX_TOP;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (adv) begin
      if (col_end) begin
        col_pos <= '0;
        row_pos <= row_end ? '0 : row_inc[lfsf_pkg::POS_W-1:0];
      end else begin
        col_pos <= col_inc[lfsf_pkg::POS_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfsf_step.sv =====
`default_nettype none

`include "largest_free_square_finder_core_defines.svh"

module lfsf_step #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_fire,
  input  wire logic                          in_free,
  input  wire lfsf_pkg::pos_t                in_pos,
  input  wire logic [$clog2(MAX_COLS)-1:0]   in_idx,
  output      logic                          in_ready,
  input  wire logic [lfsf_pkg::SIZE_W-1:0]   up,
  output      logic                          ram_we,
  output      logic [$clog2(MAX_COLS)-1:0]   ram_waddr,
  output      logic [lfsf_pkg::SIZE_W-1:0]   ram_wdata,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      lfsf_pkg::res_t                res
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int SW = lfsf_pkg::SIZE_W;
  localparam int PW = lfsf_pkg::POS_W;

  logic                b_valid;
  logic                b_free;
  lfsf_pkg::pos_t      b_pos;
  logic [AW-1:0]       b_idx;
  logic                b_fire;

  logic [SW-1:0]       left_size;
  logic [SW-1:0]       diag_size;
  logic [SW-1:0]       best_size;
  logic [PW-1:0]       best_top;
  logic [PW-1:0]       best_left;

  logic [SW-1:0]       least;
  logic [SW:0]         grown;
  logic [SW-1:0]       s_size;
  logic                better;
  logic [SW-1:0]       top_calc;
  logic [SW-1:0]       left_calc;
  logic [SW-1:0]       best_size_upd;
  logic [PW-1:0]       best_top_upd;
  logic [PW-1:0]       best_left_upd;

  // a finished grid may only leave when the result register has room
  assign b_fire   = b_valid && !(b_pos.grid_end && out_valid && !out_ready);
  assign in_ready = !b_valid || b_fire;

  always_comb begin
    least = (up < left_size) ? up : left_size;
    least = (least < diag_size) ? least : diag_size;
    grown = {1'b0, least} + (SW + 1)'(1);
    if (b_pos.row == '0 || b_pos.col == '0) begin
      s_size = SW'(b_free);
    end else if (!b_free) begin
      s_size = '0;
    end else if (grown[SW]) begin
      s_size = lfsf_pkg::SIZE_SAT;
    end else begin
      s_size = grown[SW-1:0];
    end
  end

  assign better    = s_size > best_size;
  assign top_calc  = {1'b0, b_pos.row} + SW'(1) - s_size;
  assign left_calc = {1'b0, b_pos.col} + SW'(1) - s_size;

  always_comb begin
    if (better) begin
      best_size_upd = s_size;
      best_top_upd  = top_calc[PW-1:0];
      best_left_upd = left_calc[PW-1:0];
    end else begin
      best_size_upd = best_size;
      best_top_upd  = best_top;
      best_left_upd = best_left;
    end
  end

  assign ram_we    = b_fire;
  assign ram_waddr = b_idx;
  assign ram_wdata = s_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      left_size <= '0;
      diag_size <= '0;
      best_size <= '0;
      best_top  <= '0;
      best_left <= '0;
    end else begin
      if (in_ready) begin
        b_valid <= in_fire;
      end
      if (b_fire) begin
        if (b_pos.grid_end) begin
          left_size <= '0;
          diag_size <= '0;
          best_size <= '0;
          best_top  <= '0;
          best_left <= '0;
        end else begin
          left_size <= s_size;
          diag_size <= up;
          best_size <= best_size_upd;
          best_top  <= best_top_upd;
          best_left <= best_left_upd;
        end
      end
      if (b_fire && b_pos.grid_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_free <= in_free;
      b_pos  <= in_pos;
      b_idx  <= in_idx;
    end
    if (b_fire && b_pos.grid_end) begin
      res.found       <= best_size_upd != '0;
      res.square_size <= best_size_upd;
      res.top_row     <= best_top_upd;
      res.left_col    <= best_left_upd;
    end
  end

  `LFSF_ASSERT(a_found_matches_size, out_valid |-> (res.found == (res.square_size != '0)), "found disagrees with size")
  `LFSF_ASSERT(a_best_grows, b_fire && !b_pos.grid_end |=> best_size >= $past(best_size), "best size shrank inside a grid")
  `LFSF_ASSERT(a_stall_holds, b_valid && !b_fire |=> b_valid && $stable(b_idx) && $stable(b_pos), "stalled cell lost")
  `LFSF_ASSERT_ALWAYS(a_ready_when_empty, !b_valid |-> in_ready, "empty stage refused a word")

endmodule

`default_nettype wire

// ===== rtl/largest_free_square_finder_core.sv =====
// channel  | dir | payload                                   | taken when
// cfg      | in  | index, data (col_count, row_count)        | valid && ready
// cells    | in  | cell_free, raster order                   | valid && ready
// results  | out | found, square_size, top_row, left_col     | valid && ready
//
// one cell word per cycle unless stalled; the result is registered after the last cell
// the previous-row ram read is issued as a cell is taken, its registered data meets
// the cell in the update stage, which writes the new size back in the same cycle
// cells stall only while a finished grid waits behind a full result register
// rst is synchronous; counts come back as 1024, ram contents are left as they are
`default_nettype none

module largest_free_square_finder_core #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  lfsf_cfg_if.sink        cfg,
  lfsf_cell_if.sink       cells,
  lfsf_result_if.source   results
);

  localparam int AW = $clog2(MAX_COLS);

  logic [lfsf_pkg::CNT_W-1:0]  col_count;
  logic [lfsf_pkg::CNT_W-1:0]  row_count;
  logic                        in_fire;
  logic                        in_ready;
  lfsf_pkg::pos_t              cur;
  logic [AW-1:0]               idx;
  logic [lfsf_pkg::SIZE_W-1:0] up;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [lfsf_pkg::SIZE_W-1:0] ram_wdata;
  lfsf_pkg::res_t              res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= lfsf_pkg::CNT_RESET;
      row_count <= lfsf_pkg::CNT_RESET;
    end else if (cfg.valid) begin
      unique case (lfsf_pkg::cfg_reg_t'(cfg.index))
        lfsf_pkg::REG_COL_COUNT: col_count <= cfg.data;
        lfsf_pkg::REG_ROW_COUNT: row_count <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cells.ready = in_ready;
  assign in_fire     = cells.valid && in_ready;

  lfsf_pos #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .adv       (in_fire),
    .col_count (col_count),
    .row_count (row_count),
    .cur       (cur),
    .idx       (idx)
  );

  // one row of sizes, read ahead for the cell being taken
  lfsf_ram #(
    .WIDTH (lfsf_pkg::SIZE_W),
    .DEPTH (MAX_COLS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (idx),
    .rdata (up)
  );

  lfsf_step #(
    .MAX_COLS (MAX_COLS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_free   (cells.cell_free),
    .in_pos    (cur),
    .in_idx    (idx),
    .in_ready  (in_ready),
    .up        (up),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .res       (res)
  );

  assign results.found       = res.found;
  assign results.square_size = res.square_size;
  assign results.top_row     = res.top_row;
  assign results.left_col    = res.left_col;

endmodule

`default_nettype wire
